FILE: sv/tof_sensor_frame_deframer_macros.svh
// Assertion helpers used by the checker file tofdf_checker.sv.
`ifndef TOF_SENSOR_FRAME_DEFRAMER_MACROS_SVH
`define TOF_SENSOR_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TOFDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TOFDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tofdf_pkg.sv
package tofdf_pkg;

  localparam logic [7:0]  HDR_FIRST    = 8'hAA;
  localparam logic [7:0]  HDR_SECOND   = 8'h55;
  localparam logic [7:0]  STAT_GOOD_A  = 8'd5;
  localparam logic [7:0]  STAT_GOOD_B  = 8'd9;
  localparam logic [7:0]  STAT_GOOD_C  = 8'd10;
  localparam logic [15:0] DIST_INVALID = 16'hFFFF;
  localparam logic [15:0] MASK_RESET   = 16'h0020;

  localparam int MEAS_DEF     = 16;
  localparam int POS_W        = 6;   // widest position for up to 64 measurements
  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_TDATA_W  = 40;

  // One status beat on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0]  src_id;
    logic [3:0]  meas_index;
    logic        maskable;     // position has a mask bit
    logic [15:0] distance;
    logic [7:0]  status_code;
    logic        frame_last;
  } tofdf_item_t;

  function automatic logic status_good(input logic [7:0] s);
    status_good = s inside {STAT_GOOD_A, STAT_GOOD_B, STAT_GOOD_C};
  endfunction

endpackage

FILE: sv/tof_sensor_frame_deframer.sv
// Time-of-flight sensor frame deframer. Feed received serial bytes one per
// beat on in_tdata; the block hunts for the header 0xAA 0x55 (a repeated
// 0xAA keeps the hunt going), then takes a sensor ID byte, MEAS_PER_FRAME
// little-endian 16-bit distances and MEAS_PER_FRAME status bytes. Once the
// header is seen, every following byte is frame content: there is no
// resync inside a frame and no checksum. Each status byte yields one output
// beat carrying ID, index, distance and raw status, with out_tlast on the
// last measurement of the frame. Where filter_mask has a bit set for the
// index (indices 0..15 only) and the status is not 5, 9 or 10, the distance
// reads 0xFFFF. Write cfg_wdata with cfg_we only while the stream is idle.
// Rate: one byte per clock, sustained. The parser state machine takes a byte
// every cycle; in_tready drops only during the status section when the
// 4-entry queue ahead of the output register is full, i.e. when out_tready
// has been held low. A result passes through a queue slot and then the output register.
// The distance store is a small RAM, read one position ahead of the parser.
module tof_sensor_frame_deframer #(
  parameter int MEAS_PER_FRAME = tofdf_pkg::MEAS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte stream in
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  // measurement results out
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] src_id, [11:8] meas_index, [27:12] distance,
  // [35:28] status_code, [39:36] zero
  output logic [tofdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,  // frame_last
  // filter_mask register
  input  logic                            cfg_we,
  input  logic [15:0]                     cfg_wdata
);
  import tofdf_pkg::*;

  logic [15:0] mask_r;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  tofdf_item_t q_in;
  tofdf_item_t q_head;

  // Hold the filter mask; the user must see that it is written only between frames, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // Front: header hunt, distance capture, one queue entry per status byte.
  tofdf_front #(
    .MEAS_PER_FRAME (MEAS_PER_FRAME)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // Decouple the parser from output back-pressure.
  tofdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: apply the status filter and drive the registered output beat.
  tofdf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .filter_mask (mask_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

FILE: sv/tofdf_ram.sv
module tofdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // write-first on a same-address collision
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tofdf_front.sv
module tofdf_front #(
  parameter int MEAS_PER_FRAME = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   q_full,
  output logic                   q_push,
  output tofdf_pkg::tofdf_item_t q_item
);
  import tofdf_pkg::*;

  localparam int IDX_W = (MEAS_PER_FRAME > 1) ? $clog2(MEAS_PER_FRAME) : 1;
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(MEAS_PER_FRAME - 1);

  localparam logic [2:0] PH_HUNT0 = 3'd0;
  localparam logic [2:0] PH_HUNT1 = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_DLO   = 3'd3;
  localparam logic [2:0] PH_DHI   = 3'd4;
  localparam logic [2:0] PH_STAT  = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [7:0]       id_r, id_nxt;
  logic             acc;
  logic             ram_we;
  logic [15:0]      ram_rdata;
  logic [POS_W-1:0] pos_ext;

  assign in_tready = !((phase_r == PH_STAT) && q_full);
  assign acc       = in_tvalid && in_tready;
  assign pos_ext   = POS_W'(pos_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    low_nxt   = low_r;
    id_nxt    = id_r;
    ram_we    = 1'b0;
    q_push    = 1'b0;
    case (phase_r)
      PH_HUNT0: begin
        if (acc && (in_tdata == HDR_FIRST)) phase_nxt = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (acc) begin
          if (in_tdata == HDR_SECOND) begin
            phase_nxt = PH_ID;
          end else if (in_tdata != HDR_FIRST) begin
            phase_nxt = PH_HUNT0;
          end
        end
      end
      PH_ID: begin
        if (acc) begin
          id_nxt    = in_tdata;
          pos_nxt   = '0;
          phase_nxt = PH_DLO;
        end
      end
      PH_DLO: begin
        if (acc) begin
          low_nxt   = in_tdata;
          phase_nxt = PH_DHI;
        end
      end
      PH_DHI: begin
        if (acc) begin
          ram_we = 1'b1;
          if (pos_r == POS_LAST) begin
            pos_nxt   = '0;
            phase_nxt = PH_STAT;
          end else begin
            pos_nxt   = pos_r + IDX_W'(1);
            phase_nxt = PH_DLO;
          end
        end
      end
      PH_STAT: begin
        if (acc) begin
          q_push = 1'b1;
          if (pos_r == POS_LAST) begin
            pos_nxt   = '0;
            phase_nxt = PH_HUNT0;
          end else begin
            pos_nxt = pos_r + IDX_W'(1);
          end
        end
      end
      default: phase_nxt = PH_HUNT0;
    endcase
  end

  always_comb begin
    q_item.src_id      = id_r;
    q_item.meas_index  = pos_ext[3:0];
    q_item.maskable    = (pos_ext < POS_W'(16));
    q_item.distance    = ram_rdata;
    q_item.status_code = in_tdata;
    q_item.frame_last  = (pos_r == POS_LAST);
  end

  // Read address follows the next position, so the entry for the coming
  // status byte is already in the read register.
  tofdf_ram #(
    .WIDTH (16),
    .DEPTH (MEAS_PER_FRAME)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata ({in_tdata, low_r}),
    .raddr (pos_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
      pos_r   <= '0;
      low_r   <= '0;
      id_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      low_r   <= low_nxt;
      id_r    <= id_nxt;
    end
  end

endmodule

FILE: sv/tofdf_queue.sv
module tofdf_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tofdf_pkg::tofdf_item_t push_item,
  input  logic                   pop,
  output logic                   full,
  output logic                   not_empty,
  output tofdf_pkg::tofdf_item_t head
);
  import tofdf_pkg::*;

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  tofdf_item_t     slot_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_r, wr_nxt;
  logic [QA_W-1:0] rd_r, rd_nxt;
  logic [QA_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QA_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QA_W'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + QA_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QA_W + 1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (QA_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/tofdf_back.sv
module tofdf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [15:0]                     filter_mask,
  input  logic                            q_not_empty,
  input  tofdf_pkg::tofdf_item_t          q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tofdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import tofdf_pkg::*;

  logic        ov_r, ov_nxt;
  tofdf_item_t res_r, res_nxt;

  assign q_pop = q_not_empty && (!ov_r || out_tready);

  // Drop the distance where the mask selects this position and status is bad.
  always_comb begin
    res_nxt = q_head;
    if (q_head.maskable && filter_mask[q_head.meas_index] &&
        !status_good(q_head.status_code)) begin
      res_nxt.distance = DIST_INVALID;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (q_pop) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = res_r.frame_last;
  assign out_tdata  = {4'b0, res_r.status_code, res_r.distance,
                       res_r.meas_index, res_r.src_id};

endmodule

FILE: sv/tofdf_checker.sv
`include "tof_sensor_frame_deframer_macros.svh"

module tofdf_checker #(
  parameter int MEAS_PER_FRAME = tofdf_pkg::MEAS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tofdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_we,
  input logic [15:0]                     cfg_wdata
);
  import tofdf_pkg::*;

  logic       out_fire;
  logic [6:0] cnt_r;
  logic [7:0] id_r;
  logic [15:0] mask_r;
  logic [7:0] st;
  logic       st_bad;
  logic       in_fire;

  assign out_fire = out_tvalid && out_tready;
  assign in_fire  = in_tvalid && in_tready;
  assign st       = out_tdata[35:28];
  assign st_bad   = (st != STAT_GOOD_A) && (st != STAT_GOOD_B) && (st != STAT_GOOD_C);

  // Track expected position and ID of the next output beat, and the mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      id_r   <= '0;
      mask_r <= MASK_RESET;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      if (out_fire) begin
        id_r  <= out_tdata[7:0];
        cnt_r <= out_tlast ? 7'd0 : cnt_r + 7'd1;
      end
    end
  end

  `TOFDF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready && !in_fire && !cfg_we,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output beat changed")
  `TOFDF_ASSERT_NOW(a_idx_seq, out_fire, out_tdata[11:8] == cnt_r[3:0],
    "measurement index out of sequence")
  `TOFDF_ASSERT_NOW(a_last_pos, out_fire,
    out_tlast == (cnt_r == 7'(MEAS_PER_FRAME - 1)), "tlast on wrong measurement")
  `TOFDF_ASSERT_NOW(a_id_stable, out_fire && (cnt_r != 7'd0), out_tdata[7:0] == id_r,
    "sensor ID changed within a frame")
  `TOFDF_ASSERT_NOW(a_filter, out_fire && (cnt_r < 7'd16) && mask_r[cnt_r[3:0]] && st_bad,
    out_tdata[27:12] == DIST_INVALID, "masked bad-status distance not invalidated")

endmodule

bind tof_sensor_frame_deframer tofdf_checker #(
  .MEAS_PER_FRAME (MEAS_PER_FRAME)
) u_tofdf_checker (.*);
